### sv/hsv2rgb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Constants and types shared by the HSV to RGB conversion pipeline.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  localparam int unsigned NUM_STAGES = 6;

  // Thirty-six sectors of 960 units: a multiple of a full turn that lifts
  // every signed hue above zero.
  localparam logic signed [17:0] HUE_OFFSET = 18'sd34560;

  localparam logic [9:0]  SECTOR_W  = 10'd960;
  localparam logic [6:0]  SECTORS   = 7'd6;
  localparam logic [12:0] RECIP_15  = 13'd4370;
  localparam logic [11:0] RECIP_6   = 12'd43;
  localparam logic [25:0] RECIP_25  = 26'd42949673;
  localparam logic [16:0] UNIT_ONE  = 17'd65536;
  localparam logic [49:0] HALF_LSB  = 50'd2061584302080;
  localparam logic [49:0] CHAN_MAX  = 50'd255;
  localparam logic signed [15:0] RAW_ONE  = 16'sd256;
  localparam logic signed [15:0] RAW_FULL = 16'sd25600;
  localparam logic [11:0] SCALED_MAX = 12'd3832;

  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_t;

  typedef struct packed {
    logic        use_div;
    logic [16:0] u_dir;
    logic [46:0] prod;
  } unit_pre_t;

endpackage

### sv/hsv_to_rgb_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB converter
// An accepted beat passes through six registered stages to the output.
// Throughput is one beat per cycle; a stall on the output holds all stages.
// Reset clears only the stage valid bits; the datapath registers are not reset.
// The six stages are hue wrap and unit prescaling, sector division and unit
// scaling, triangle and chroma, channel terms, channel sums, and a final
// divide by fifteen into 8-bit channels.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_hue,
  input  logic signed [15:0] in_saturation,
  input  logic signed [15:0] in_brightness,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue
);
  import hsv2rgb_pkg::*;

  function automatic unit_pre_t unit_pre(input logic signed [15:0] raw);
    unit_pre_t   res;
    logic [20:0] n;
    n = 21'({raw[14:0], 6'd0}) + 21'd12;
    res.prod    = 47'(n) * 47'(RECIP_25);
    res.use_div = 1'b0;
    res.u_dir   = '0;
    if (raw < 0) begin
      res.u_dir = '0;
    end else if (raw <= RAW_ONE) begin
      res.u_dir = {raw[8:0], 8'd0};
    end else if (raw >= RAW_FULL) begin
      res.u_dir = UNIT_ONE;
    end else begin
      res.use_div = 1'b1;
    end
    return res;
  endfunction

  function automatic logic [16:0] unit_fin(input unit_pre_t p);
    return p.use_div ? p.prod[46:30] : p.u_dir;
  endfunction

  function automatic logic [11:0] chan_scale(input logic [41:0] ch, input logic [41:0] mn);
    logic [41:0] n;
    logic [49:0] dd;
    n  = ch + mn;
    dd = 50'(n) * CHAN_MAX + HALF_LSB;
    return dd[49:38];
  endfunction

  function automatic logic [7:0] div15(input logic [11:0] d);
    logic [24:0] p;
    p = 25'(d) * 25'(RECIP_15);
    return p[23:16];
  endfunction

  logic                  en;
  logic [NUM_STAGES:1]   vld_r, vld_nxt;

  logic [16:0] hu1_r, hu1_nxt;
  logic [23:0] qp1_r, qp1_nxt;
  unit_pre_t   sp1_r, sp1_nxt, vp1_r, vp1_nxt;
  logic signed [17:0] hue_ext;

  logic [6:0]  q2_r, q2_nxt;
  logic [9:0]  r2_r, r2_nxt;
  logic [16:0] s2_r, s2_nxt, v2_r, v2_nxt;
  logic [16:0] rem2;

  sector_t     sec3_r, sec3_nxt;
  logic [9:0]  k3_r, k3_nxt;
  logic [32:0] c3_r, c3_nxt;
  logic [16:0] v3_r, v3_nxt;
  logic [11:0] qm3;
  logic [6:0]  sec3_val;

  sector_t     sec4_r, sec4_nxt;
  logic [41:0] cn4_r, cn4_nxt, xn4_r, xn4_nxt, mn4_r, mn4_nxt;
  logic [32:0] vm4;

  logic [11:0] dr5_r, dr5_nxt, dg5_r, dg5_nxt, db5_r, db5_nxt;
  logic [41:0] chr, chg, chb;

  logic [7:0]  red6_r, red6_nxt, grn6_r, grn6_nxt, blu6_r, blu6_nxt;

  assign en        = !vld_r[NUM_STAGES] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[NUM_STAGES];
  assign out_red   = red6_r;
  assign out_green = grn6_r;
  assign out_blue  = blu6_r;

  assign vld_nxt = {vld_r[NUM_STAGES-1:1], in_valid & in_ready};

  always_comb begin
    hue_ext = 18'(in_hue) + HUE_OFFSET;
    hu1_nxt = hue_ext[16:0];
    qp1_nxt = 24'(hu1_nxt[16:6]) * 24'(RECIP_15);
    sp1_nxt = unit_pre(in_saturation);
    vp1_nxt = unit_pre(in_brightness);
  end

  always_comb begin
    q2_nxt = qp1_r[22:16];
    rem2   = hu1_r - 17'(q2_nxt) * 17'(SECTOR_W);
    r2_nxt = rem2[9:0];
    s2_nxt = unit_fin(sp1_r);
    v2_nxt = unit_fin(vp1_r);
  end

  always_comb begin
    qm3      = 12'(q2_r) * RECIP_6;
    sec3_val = q2_r - 7'(qm3[11:8]) * SECTORS;
    sec3_nxt = sector_t'(sec3_val[2:0]);
    k3_nxt   = q2_r[0] ? (SECTOR_W - r2_r) : r2_r;
    c3_nxt   = 33'(v2_r) * 33'(s2_r);
    v3_nxt   = v2_r;
  end

  always_comb begin
    sec4_nxt = sec3_r;
    xn4_nxt  = 42'(c3_r) * 42'(k3_r);
    cn4_nxt  = 42'(c3_r) * 42'(SECTOR_W);
    vm4      = {v3_r, 16'd0} - c3_r;
    mn4_nxt  = 42'(vm4) * 42'(SECTOR_W);
  end

  always_comb begin
    case (sec4_r)
      SEC_RY: begin
        chr = cn4_r; chg = xn4_r; chb = '0;
      end
      SEC_YG: begin
        chr = xn4_r; chg = cn4_r; chb = '0;
      end
      SEC_GC: begin
        chr = '0; chg = cn4_r; chb = xn4_r;
      end
      SEC_CB: begin
        chr = '0; chg = xn4_r; chb = cn4_r;
      end
      SEC_BM: begin
        chr = xn4_r; chg = '0; chb = cn4_r;
      end
      default: begin
        chr = cn4_r; chg = '0; chb = xn4_r;
      end
    endcase
    dr5_nxt = chan_scale(chr, mn4_r);
    dg5_nxt = chan_scale(chg, mn4_r);
    db5_nxt = chan_scale(chb, mn4_r);
  end

  always_comb begin
    red6_nxt = div15(dr5_r);
    grn6_nxt = div15(dg5_r);
    blu6_nxt = div15(db5_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hu1_r  <= hu1_nxt;
      qp1_r  <= qp1_nxt;
      sp1_r  <= sp1_nxt;
      vp1_r  <= vp1_nxt;
      q2_r   <= q2_nxt;
      r2_r   <= r2_nxt;
      s2_r   <= s2_nxt;
      v2_r   <= v2_nxt;
      sec3_r <= sec3_nxt;
      k3_r   <= k3_nxt;
      c3_r   <= c3_nxt;
      v3_r   <= v3_nxt;
      sec4_r <= sec4_nxt;
      cn4_r  <= cn4_nxt;
      xn4_r  <= xn4_nxt;
      mn4_r  <= mn4_nxt;
      dr5_r  <= dr5_nxt;
      dg5_r  <= dg5_nxt;
      db5_r  <= db5_nxt;
      red6_r <= red6_nxt;
      grn6_r <= grn6_nxt;
      blu6_r <= blu6_nxt;
    end
  end

  // The reciprocal divide of the hue must leave a remainder inside one sector.
  a_hue_rem: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[2] |-> (r2_r < SECTOR_W))
    else $error("hue remainder out of sector range");

  a_sector: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[2] |-> (sec3_val < SECTORS))
    else $error("sector index out of range");

  a_chroma: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[3] |-> ((c3_r <= {1'b1, 32'd0}) && (k3_r <= SECTOR_W)))
    else $error("chroma or triangle term above unity");

  a_scaled: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[5] |-> ((dr5_r <= SCALED_MAX) && (dg5_r <= SCALED_MAX) && (db5_r <= SCALED_MAX)))
    else $error("scaled channel above full scale");

endmodule
